// ===== design/glzw_pkg.sv =====
// Shared types and constants for the GIF LZW compressor.
// Used by every module of the block; no dependencies.
package glzw_pkg;

    localparam int MAX_CODES_DEF     = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int DICT_SLOTS_DEF    = 8192;

    // Widest code the port structures carry, and dictionary key width
    localparam int CODE_MAX_W = 12;
    localparam int KEY_W      = 20;
    localparam int EPOCH_W    = 8;
    localparam int WIDTH_W    = 4;

    localparam logic [3:0]  MCS_RESET = 4'd8;
    localparam logic [3:0]  MCS_LOW   = 4'd2;
    localparam logic [3:0]  MCS_HIGH  = 4'd8;
    localparam logic [31:0] HASH_MUL  = 32'h9E37_79B1;
    localparam int          HASH_SHIFT = 7;

    // Configuration register indexes
    localparam logic REG_MIN_CODE_SIZE = 1'b0;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } q_item_t;

    typedef struct packed {
        logic                  valid;
        logic [CODE_MAX_W-1:0] code;
        logic [WIDTH_W-1:0]    width;
        logic                  final_code;
    } code_req_t;

    typedef struct packed {
        logic in_stream;
        logic clearing;
    } eng_status_t;

    typedef struct packed {
        logic                  valid;
        logic [EPOCH_W-1:0]    epoch;
        logic [KEY_W-1:0]      key;
        logic [CODE_MAX_W-1:0] code;
    } dict_word_t;

endpackage

// ===== design/glzw_front.sv =====
// Front end: configuration register port, pixel request intake and a
// two-entry queue towards the engine. Depends on glzw_pkg.
module glzw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  logic [7:0]           pixel_index,
    input  logic                 last_pixel,
    input  glzw_pkg::eng_status_t status,
    input  logic                 q_pop,
    output logic                 q_valid,
    output glzw_pkg::q_item_t    q_item,
    output logic [3:0]           mcs
);

    logic [3:0]        mcs_reg;
    logic [3:0]        wr_val;
    glzw_pkg::q_item_t q_mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              push;
    logic [7:0]        pix_mask;

    assign pready = 1'b1;
    assign mcs    = mcs_reg;

    // Clamp the written code size into its legal range
    always_comb
    begin
        wr_val = pwdata[3:0];
        if (wr_val < glzw_pkg::MCS_LOW)
        begin
            wr_val = glzw_pkg::MCS_LOW;
        end
        else if (wr_val > glzw_pkg::MCS_HIGH)
        begin
            wr_val = glzw_pkg::MCS_HIGH;
        end
    end

    // Hold the register; drop writes during a stream or beyond the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg <= glzw_pkg::MCS_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == glzw_pkg::REG_MIN_CODE_SIZE)
                 && !status.in_stream)
        begin
            mcs_reg <= wr_val;
        end
    end

    assign prdata = (paddr[2] == glzw_pkg::REG_MIN_CODE_SIZE) ? {28'd0, mcs_reg} : 32'd0;

    // Accept a request while the queue has room and no clearing pass runs
    assign pixel_stall = (cnt_reg == 2'd2) || status.clearing;
    assign push        = pixel_valid && !pixel_stall;
    assign pix_mask    = ~(8'hFF << mcs_reg);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{pix: pixel_index & pix_mask, last: last_pixel};
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_mem[rd_ptr_reg];

endmodule

// ===== design/glzw_packer.sv =====
// Bit packer: takes codes LSB-first, hands out bytes through an output
// register, and flushes the partial byte at stream end. Depends on glzw_pkg.
module glzw_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  glzw_pkg::code_req_t req,
    output logic                req_ready,
    output logic                byte_valid,
    input  logic                byte_stall,
    output logic [7:0]          code_byte,
    output logic                last_byte
);

    logic [19:0] acc_reg;
    logic [4:0]  cnt_reg;
    logic        final_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        slot_free;
    logic        drain;
    logic [glzw_pkg::CODE_MAX_W-1:0] mask;

    assign slot_free = !out_valid_reg || !byte_stall;
    assign drain     = slot_free && ((cnt_reg >= 5'd8) || (final_reg && (cnt_reg != 5'd0)));
    assign req_ready = (cnt_reg < 5'd8) && !final_reg;
    assign mask      = ~({glzw_pkg::CODE_MAX_W{1'b1}} << req.width);

    // Merge codes and shift out whole bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            final_reg <= 1'b0;
        end
        else if (req.valid && req_ready)
        begin
            acc_reg   <= acc_reg | (20'(req.code & mask) << cnt_reg);
            cnt_reg   <= cnt_reg + 5'(req.width);
            final_reg <= req.final_code;
        end
        else if (drain)
        begin
            acc_reg <= acc_reg >> 8;
            cnt_reg <= (cnt_reg > 5'd8) ? cnt_reg - 5'd8 : 5'd0;
            if (cnt_reg <= 5'd8)
            begin
                final_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= drain;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_byte_reg <= acc_reg[7:0];
            out_last_reg <= final_reg && (cnt_reg <= 5'd8);
        end
    end

    assign byte_valid = out_valid_reg;
    assign code_byte  = out_byte_reg;
    assign last_byte  = out_last_reg;

endmodule

// ===== design/glzw_engine.sv =====
// LZW engine: hashed dictionary with linear probing, prefix and code width
// tracking, and code requests to the packer. Depends on glzw_pkg.
module glzw_engine #(
    parameter int MAX_CODES     = glzw_pkg::MAX_CODES_DEF,
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
    parameter int DICT_SLOTS    = glzw_pkg::DICT_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [3:0]            mcs,
    input  logic                  q_valid,
    input  glzw_pkg::q_item_t     q_item,
    output logic                  q_pop,
    output glzw_pkg::code_req_t   req,
    input  logic                  req_ready,
    output glzw_pkg::eng_status_t status
);

    localparam int AW    = $clog2(DICT_SLOTS);
    localparam int NFC_W = $clog2(MAX_CODES + 1);
    localparam int CW    = MAX_CODE_BITS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_START = 10'b0000000010,
        S_HASH  = 10'b0000000100,
        S_READ  = 10'b0000001000,
        S_CMP   = 10'b0000010000,
        S_MISS  = 10'b0000100000,
        S_FULL  = 10'b0001000000,
        S_END1  = 10'b0010000000,
        S_END2  = 10'b0100000000,
        S_CLEAR = 10'b1000000000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            in_stream_reg, in_stream_next;
    logic [CW-1:0]                   prefix_reg, prefix_next;
    logic [NFC_W-1:0]                nfc_reg, nfc_next;
    logic [glzw_pkg::WIDTH_W-1:0]    width_reg, width_next;
    logic [glzw_pkg::EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic                            clr_pend_reg, clr_pend_next;
    logic [AW-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [7:0]                      pix_reg, pix_next;
    logic                            last_reg, last_next;
    logic [glzw_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [AW-1:0]                   slot_reg, slot_next;
    glzw_pkg::dict_word_t            rd_word_reg;
    glzw_pkg::dict_word_t            dict_mem [DICT_SLOTS];
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    glzw_pkg::dict_word_t            mem_wdata;
    logic [31:0]                     hash_prod;
    logic [glzw_pkg::CODE_MAX_W-1:0] clear_code;
    logic [NFC_W-1:0]                nfc_inc;
    logic [13:0]                     width_pow;
    logic                            entry_live;

    assign clear_code = glzw_pkg::CODE_MAX_W'(1) << mcs;
    assign hash_prod  = 32'(key_reg) * glzw_pkg::HASH_MUL;
    assign nfc_inc    = nfc_reg + NFC_W'(1);
    assign width_pow  = 14'(1) << width_reg;
    assign entry_live = rd_word_reg.valid && (rd_word_reg.epoch == epoch_reg);

    // Dictionary memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= dict_mem[slot_reg];
    end

    // Sequence one item: start, probe, emit, end; also run the clearing pass
    always_comb
    begin
        state_next     = state_reg;
        in_stream_next = in_stream_reg;
        prefix_next    = prefix_reg;
        nfc_next       = nfc_reg;
        width_next     = width_reg;
        epoch_next     = epoch_reg;
        clr_pend_next  = clr_pend_reg;
        clr_cnt_next   = clr_cnt_reg;
        pix_next       = pix_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        slot_next      = slot_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = '{valid: 1'b1, epoch: epoch_reg, key: key_reg,
                           code: glzw_pkg::CODE_MAX_W'(nfc_reg)};
        req            = '{valid: 1'b0, code: clear_code, width: width_reg,
                           final_code: 1'b0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (clr_pend_reg)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_CLEAR;
                end
                else if (q_valid)
                begin
                    q_pop     = 1'b1;
                    pix_next  = q_item.pix;
                    last_next = q_item.last;
                    key_next  = {glzw_pkg::CODE_MAX_W'(prefix_reg), q_item.pix};
                    if (!in_stream_reg)
                    begin
                        // Restart the table and open the stream
                        width_next     = glzw_pkg::WIDTH_W'(mcs) + 1'b1;
                        nfc_next       = NFC_W'(clear_code) + NFC_W'(2);
                        epoch_next     = epoch_reg + 1'b1;
                        clr_pend_next  = (epoch_next == '0);
                        prefix_next    = CW'(q_item.pix);
                        in_stream_next = 1'b1;
                        state_next     = S_START;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_START:
            begin
                req.valid = 1'b1;
                if (req_ready)
                begin
                    state_next = last_reg ? S_END1 : S_IDLE;
                end
            end
            S_HASH:
            begin
                slot_next  = hash_prod[glzw_pkg::HASH_SHIFT +: AW];
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!entry_live)
                begin
                    state_next = S_MISS;
                end
                else if (rd_word_reg.key == key_reg)
                begin
                    prefix_next = CW'(rd_word_reg.code);
                    state_next  = last_reg ? S_END1 : S_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_MISS:
            begin
                req.valid = 1'b1;
                req.code  = glzw_pkg::CODE_MAX_W'(prefix_reg);
                if (req_ready)
                begin
                    prefix_next = CW'(pix_reg);
                    if (nfc_reg < NFC_W'(MAX_CODES))
                    begin
                        // Add the pair at the empty slot the probe found
                        mem_we   = 1'b1;
                        nfc_next = nfc_inc;
                        if ((14'(nfc_inc) > width_pow) &&
                            (width_reg < glzw_pkg::WIDTH_W'(MAX_CODE_BITS)))
                        begin
                            width_next = width_reg + 1'b1;
                        end
                        state_next = last_reg ? S_END1 : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FULL;
                    end
                end
            end
            S_FULL:
            begin
                req.valid = 1'b1;
                if (req_ready)
                begin
                    width_next    = glzw_pkg::WIDTH_W'(mcs) + 1'b1;
                    nfc_next      = NFC_W'(clear_code) + NFC_W'(2);
                    epoch_next    = epoch_reg + 1'b1;
                    clr_pend_next = (epoch_next == '0);
                    state_next    = last_reg ? S_END1 : S_IDLE;
                end
            end
            S_END1:
            begin
                req.valid = 1'b1;
                req.code  = glzw_pkg::CODE_MAX_W'(prefix_reg);
                if (req_ready)
                begin
                    state_next = S_END2;
                end
            end
            S_END2:
            begin
                req.valid      = 1'b1;
                req.code       = clear_code + 1'b1;
                req.final_code = 1'b1;
                if (req_ready)
                begin
                    in_stream_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                // Invalidate one slot per cycle
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DICT_SLOTS - 1))
                begin
                    clr_pend_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stream_reg <= 1'b0;
            prefix_reg    <= '0;
            nfc_reg       <= '0;
            width_reg     <= '0;
            epoch_reg     <= '0;
            clr_pend_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stream_reg <= in_stream_next;
            prefix_reg    <= prefix_next;
            nfc_reg       <= nfc_next;
            width_reg     <= width_next;
            epoch_reg     <= epoch_next;
            clr_pend_reg  <= clr_pend_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        last_reg <= last_next;
        key_reg  <= key_next;
        slot_reg <= slot_next;
    end

    assign status = '{in_stream: in_stream_reg, clearing: clr_pend_reg};

    // A compare always follows a memory read
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_READ))
        else $error("compare without preceding read");

    // Width stays in range throughout a stream
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_stream_reg |-> ((width_reg >= 4'd3) &&
                           (width_reg <= glzw_pkg::WIDTH_W'(MAX_CODE_BITS))))
        else $error("code width out of range");

    // Free code never passes the table size
    a_nfc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfc_reg <= NFC_W'(MAX_CODES))
        else $error("next free code overflow");

    // No item is taken while a clearing pass is owed
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_pend_reg |-> !q_pop)
        else $error("item taken during clearing");

endmodule

// ===== design/gif_lzw_compressor.sv =====
// GIF LZW compressor, top level: configuration port, pixel channel and
// byte channel. Depends on glzw_pkg, glzw_front, glzw_engine, glzw_packer.
//
// Usage: write min_code_size (byte address 0) between streams. Send pixels
// on pixel_valid/pixel_stall with last_pixel on the final pixel of a frame;
// packed LSB-first code bytes leave on byte_valid/byte_stall, last_byte
// marking the final byte of the frame.
// After reset a clearing pass walks the dictionary memory, one slot per
// cycle over all DICT_SLOTS slots (8192 by default), with pixel_stall high;
// the same pass repeats after every 256 table restarts.
// Per pixel: a stream start emits the clear code; otherwise hashing, and one
// read plus compare per probe of the dictionary, lead to a hit or an empty
// slot; a miss adds a state for the emitted code. The last pixel adds two
// code requests.
// A two-entry queue decouples intake from the engine; a stalled byte
// channel holds the output register and, once the packer fills, the engine.
module gif_lzw_compressor #(
    parameter int MAX_CODES     = glzw_pkg::MAX_CODES_DEF,
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
    parameter int DICT_SLOTS    = glzw_pkg::DICT_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  pixel_index,
    input  logic        last_pixel,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  code_byte,
    output logic        last_byte
);

    glzw_pkg::eng_status_t status;
    glzw_pkg::q_item_t     q_item;
    glzw_pkg::code_req_t   req;
    logic                  q_valid;
    logic                  q_pop;
    logic                  req_ready;
    logic [3:0]            mcs;

    glzw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel),
        .status      (status),
        .q_pop       (q_pop),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .mcs         (mcs)
    );

    glzw_engine #(
        .MAX_CODES     (MAX_CODES),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .DICT_SLOTS    (DICT_SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .mcs       (mcs),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .req       (req),
        .req_ready (req_ready),
        .status    (status)
    );

    glzw_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .req_ready  (req_ready),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .code_byte  (code_byte),
        .last_byte  (last_byte)
    );

endmodule

// ===== tb/gif_lzw_compressor_test.sv =====
// Self-checking testbench for the GIF LZW compressor top level.
// Depends on glzw_pkg and gif_lzw_compressor; predicts the packed byte stream
// per accepted pixel request and checks every byte leaving the block.
module gif_lzw_compressor_test;

    typedef struct {
        logic [7:0] code_byte;
        logic       last_byte;
    } byte_exp_t;

    typedef struct {
        bit          do_wr;
        logic [2:0]  wr_addr;
        logic [31:0] wr_val;
        logic [7:0]  pix;
        logic        last;
        int          n_typed;
        logic [7:0]  typed [4];
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        pixel_valid = 1'b0;
    logic        pixel_stall;
    logic [7:0]  pixel_index = '0;
    logic        last_pixel = 1'b0;
    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  code_byte;
    logic        last_byte;

    byte_exp_t pending_bytes [$];
    int        err_count = 0;
    bit        calm = 1'b0;
    int        hold_left = 0;

    // Shadow of the compressor state
    logic [3:0]  m_mcs = glzw_pkg::MCS_RESET;
    bit          m_open = 1'b0;
    logic [11:0] m_prefix = '0;
    int unsigned m_next = 0;
    int unsigned m_width = 0;
    logic [31:0] m_acc = '0;
    int unsigned m_nbits = 0;
    int unsigned m_dict [int unsigned];
    int          m_step_bytes;

    gif_lzw_compressor DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
        .pixel_index(pixel_index), .last_pixel(last_pixel),
        .byte_valid(byte_valid), .byte_stall(byte_stall),
        .code_byte(code_byte), .last_byte(last_byte)
    );

    always #5 clk = ~clk;

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_exp_t e;
        if (m_step_bytes < 7)
        begin
            e.code_byte = b;
            e.last_byte = 1'b0;
            pending_bytes.insert(pending_bytes.size(), e);
            m_step_bytes++;
        end
    endtask

    task automatic pack_code(input int unsigned code);
        m_acc = m_acc | ((code & ((32'd1 << m_width) - 1)) << m_nbits);
        m_nbits += m_width;
        while (m_nbits >= 8)
        begin
            push_byte(m_acc[7:0]);
            m_acc = m_acc >> 8;
            m_nbits -= 8;
        end
    endtask

    task automatic restart_dict();
        m_dict.delete();
        m_width = m_mcs + 1;
        m_next = (1 << m_mcs) + 2;
    endtask

    // Mirror a register write
    task automatic shadow_write(input logic [2:0] addr, input logic [31:0] val);
        logic [3:0] v;
        v = val[3:0];
        if (addr != {glzw_pkg::REG_MIN_CODE_SIZE, 2'b00} || m_open)
            return;
        if (v < glzw_pkg::MCS_LOW)
            v = glzw_pkg::MCS_LOW;
        if (v > glzw_pkg::MCS_HIGH)
            v = glzw_pkg::MCS_HIGH;
        m_mcs = v;
    endtask

    // Advance the shadow by one pixel and queue the bytes it produces
    task automatic predict_pixel(input logic [7:0] pix_in, input logic last);
        int unsigned clear_code;
        int unsigned pix;
        int unsigned key;
        clear_code = 1 << m_mcs;
        pix = pix_in & (clear_code - 1);
        m_step_bytes = 0;
        if (!m_open)
        begin
            restart_dict();
            m_acc = '0;
            m_nbits = 0;
            pack_code(clear_code);
            m_prefix = 12'(pix);
            m_open = 1'b1;
        end
        else
        begin
            key = (int'(m_prefix) << 8) | pix;
            if (m_dict.exists(key))
                m_prefix = 12'(m_dict[key]);
            else
            begin
                pack_code(m_prefix);
                m_prefix = 12'(pix);
                if (m_next < glzw_pkg::MAX_CODES_DEF)
                begin
                    m_dict[key] = m_next & 12'hFFF;
                    m_next++;
                    if (m_next > (1 << m_width) && m_width < glzw_pkg::MAX_CODE_BITS_DEF)
                        m_width++;
                end
                else
                begin
                    pack_code(clear_code);
                    restart_dict();
                end
            end
        end
        if (last)
        begin
            pack_code(m_prefix);
            pack_code(clear_code + 1);
            if (m_nbits > 0)
                push_byte(m_acc[7:0]);
            if (m_step_bytes > 0)
                pending_bytes[$].last_byte = 1'b1;
            m_acc = '0;
            m_nbits = 0;
            m_open = 1'b0;
        end
    endtask

    // Offer one pixel request and hold it until accepted
    task automatic send_pixel(input logic [7:0] pix, input logic last, input int n_typed,
                              input logic [7:0] typed [4]);
        int gap;
        byte_exp_t e;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_index <= pix;
        last_pixel <= last;
        do
            @(posedge clk);
        while (pixel_stall);
        if (n_typed == 0)
            predict_pixel(pix, last);
        else
        begin
            // Advance the shadow, but check the hand-worked bytes
            predict_pixel(pix, last);
            repeat (m_step_bytes) void'(pending_bytes.pop_back());
            for (int i = 0; i < n_typed; i++)
            begin
                e.code_byte = typed[i];
                e.last_byte = (i == n_typed - 1);
                pending_bytes.insert(pending_bytes.size(), e);
            end
        end
    endtask

    task automatic send_plain(input logic [7:0] pix, input logic last);
        logic [7:0] none [4];
        none = '{default: '0};
        send_pixel(pix, last, 0, none);
    endtask

    // Drop valid and wait until every expected byte has left
    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_write(addr, val);
        @(posedge clk);
    endtask

    // Byte channel: check accepted bytes, then choose the next stall
    initial
    begin
        int stall_left;
        byte_exp_t e;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (byte_valid && !byte_stall)
            begin
                if (pending_bytes.size() == 0)
                    report($sformatf("unexpected byte %02h", code_byte));
                else
                begin
                    e = pending_bytes.pop_front();
                    if (code_byte !== e.code_byte)
                        report($sformatf("code_byte %02h, want %02h", code_byte, e.code_byte));
                    if (last_byte !== e.last_byte)
                        report($sformatf("last_byte %b, want %b", last_byte, e.last_byte));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                byte_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                byte_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                byte_stall <= 1'b1;
            end
            else
                byte_stall <= 1'b0;
        end
    end

    // Hard limit on the run
    initial
    begin
        #20_000_000;
        $display("gif_lzw_compressor_test: done, errors");
        $finish;
    end

    initial
    begin
        stim_row_t rows [18];
        logic [7:0] alpha;
        logic [7:0] pix;
        int sent;

        rows[0]  = '{0, 3'd0, 32'd0, 8'h00, 1, 4, '{8'h00, 8'h01, 8'h04, 8'h04}};
        rows[1]  = '{1, 3'd0, 32'd2, 8'hFF, 1, 2, '{8'h5C, 8'h01, 8'h00, 8'h00}};
        rows[2]  = '{1, 3'd0, 32'd0, 8'h01, 0, 0, '{default: '0}};
        rows[3]  = '{0, 3'd0, 32'd0, 8'h02, 0, 0, '{default: '0}};
        rows[4]  = '{0, 3'd0, 32'd0, 8'h01, 0, 0, '{default: '0}};
        rows[5]  = '{0, 3'd0, 32'd0, 8'h02, 0, 0, '{default: '0}};
        rows[6]  = '{0, 3'd0, 32'd0, 8'h01, 0, 0, '{default: '0}};
        rows[7]  = '{0, 3'd0, 32'd0, 8'h02, 1, 0, '{default: '0}};
        rows[8]  = '{1, 3'd0, 32'hF, 8'hFF, 0, 0, '{default: '0}};
        rows[9]  = '{1, 3'd0, 32'd3, 8'h00, 0, 0, '{default: '0}};
        rows[10] = '{0, 3'd0, 32'd0, 8'hFF, 0, 0, '{default: '0}};
        rows[11] = '{0, 3'd0, 32'd0, 8'h00, 0, 0, '{default: '0}};
        rows[12] = '{0, 3'd0, 32'd0, 8'hFF, 1, 0, '{default: '0}};
        rows[13] = '{1, 3'd4, 32'd2, 8'h80, 0, 0, '{default: '0}};
        rows[14] = '{0, 3'd0, 32'd0, 8'h80, 0, 0, '{default: '0}};
        rows[15] = '{0, 3'd0, 32'd0, 8'h80, 0, 0, '{default: '0}};
        rows[16] = '{0, 3'd0, 32'd0, 8'h80, 1, 0, '{default: '0}};
        rows[17] = '{1, 3'd0, 32'd7, 8'h55, 1, 0, '{default: '0}};

        // Reset, then let the dictionary clearing pass run behind pixel_stall
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (rows[i])
        begin
            if (rows[i].do_wr)
                reg_write(rows[i].wr_addr, rows[i].wr_val);
            send_pixel(rows[i].pix, rows[i].last, rows[i].n_typed, rows[i].typed);
        end

        // Random streams with random content and occasional out-of-range pixels
        sent = 0;
        alpha = 8'h03;
        while (sent < 260)
        begin
            if (!m_open)
            begin
                if ($urandom_range(0, 2) == 0)
                    reg_write(3'd0, $urandom_range(0, 15));
                case ($urandom_range(0, 3))
                    0: alpha = 8'hFF;
                    1: alpha = 8'h01;
                    default: alpha = 8'((1 << $urandom_range(1, 3)) - 1);
                endcase
            end
            if (sent == 20)
                hold_left = 300;
            if (sent == 130)
                drain();
            // Run the closing stretch without idling
            if (sent == 220)
                calm = 1'b1;
            pix = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, alpha));
            send_plain(pix, $urandom_range(0, 24) == 0);
            sent++;
        end
        if (m_open)
            send_plain(8'($urandom_range(0, 255)), 1'b1);
        pixel_valid <= 1'b0;

        // Let every expected byte arrive, then a little more
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (err_count == 0 && pending_bytes.size() == 0)
            $display("gif_lzw_compressor_test: done, clean");
        else
            $display("gif_lzw_compressor_test: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
design/glzw_pkg.sv
design/glzw_front.sv
design/glzw_packer.sv
design/glzw_engine.sv
design/gif_lzw_compressor.sv
tb/gif_lzw_compressor_test.sv
